>>> hw/rtl/alm_pkg.sv
// Shared types, widths and register codes for the allocation latency monitor.
package alm_pkg;

	localparam int WAIT_WIDTH  = 32;
	localparam int COUNT_WIDTH = 32;
	localparam int THR_WIDTH   = 31;
	localparam int CMP_WIDTH   = (WAIT_WIDTH > THR_WIDTH) ? WAIT_WIDTH : THR_WIDTH;
	localparam int FIELD_WIDTH = 32;
	localparam int ORDER_WIDTH = 4;
	localparam int ADDR_WIDTH  = 3;

	typedef enum logic [ADDR_WIDTH-1:0] {
		REG_MONITOR_EN  = 3'd0,
		REG_LOG_EN      = 3'd1,
		REG_TRIGGER_EN  = 3'd2,
		REG_HIGH_THR    = 3'd3,
		REG_LOW_THR     = 3'd4,
		REG_LOG_THR     = 3'd5,
		REG_TRIGGER_THR = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                 monitor_en;
		logic                 log_en;
		logic                 trigger_en;
		logic [THR_WIDTH-1:0] high_thr;
		logic [THR_WIDTH-1:0] low_thr;
		logic [THR_WIDTH-1:0] log_thr;
		logic [THR_WIDTH-1:0] trigger_thr;
	} cfg_t;

	typedef struct packed {
		logic update;
		logic is_high;
		logic is_low;
	} class_ev_t;

endpackage

>>> hw/rtl/alm_cfg_regs.sv
// Configuration register file of the allocation latency monitor.
module alm_cfg_regs
	import alm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [ADDR_WIDTH-1:0] cfg_addr,
	input  logic [THR_WIDTH-1:0]  cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.monitor_en  <= 1'b0;
			cfg_q.log_en      <= 1'b0;
			cfg_q.trigger_en  <= 1'b0;
			cfg_q.high_thr    <= THR_WIDTH'(500);
			cfg_q.low_thr     <= THR_WIDTH'(100);
			cfg_q.log_thr     <= THR_WIDTH'(1000);
			cfg_q.trigger_thr <= THR_WIDTH'(10000);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_MONITOR_EN:  cfg_q.monitor_en  <= cfg_wdata[0];
				REG_LOG_EN:      cfg_q.log_en      <= cfg_wdata[0];
				REG_TRIGGER_EN:  cfg_q.trigger_en  <= cfg_wdata[0];
				REG_HIGH_THR:    cfg_q.high_thr    <= cfg_wdata;
				REG_LOW_THR:     cfg_q.low_thr     <= cfg_wdata;
				REG_LOG_THR:     cfg_q.log_thr     <= cfg_wdata;
				REG_TRIGGER_THR: cfg_q.trigger_thr <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/alm_class_stats.sv
// Peak wait and saturating high/low counters for one event class.
module alm_class_stats
	import alm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  class_ev_t              ev,
	input  logic [WAIT_WIDTH-1:0]  wait_ms,
	output logic [WAIT_WIDTH-1:0]  peak,
	output logic [COUNT_WIDTH-1:0] high_total,
	output logic [COUNT_WIDTH-1:0] low_cnt
);

	logic [WAIT_WIDTH-1:0]  peak_q;
	logic [COUNT_WIDTH-1:0] high_q;
	logic [COUNT_WIDTH-1:0] low_q;
	logic                   new_peak;

	assign new_peak = ev.update && (wait_ms > peak_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			high_q <= '0;
			low_q  <= '0;
		end else begin
			if (new_peak)
				peak_q <= wait_ms;
			if (ev.update && ev.is_high && (high_q != '1))
				high_q <= high_q + COUNT_WIDTH'(1);
			if (ev.update && ev.is_low && (low_q != '1))
				low_q <= low_q + COUNT_WIDTH'(1);
		end
	end

	assign peak       = peak_q;
	assign high_total = high_q;
	assign low_cnt    = low_q;

endmodule

>>> hw/rtl/alm_event_class.sv
// Threshold compare of one registered request into high, low, log and trigger.
module alm_event_class
	import alm_pkg::*;
(
	input  cfg_t                  cfg,
	input  logic [WAIT_WIDTH-1:0] wait_ms,
	output logic                  is_high,
	output logic                  is_low,
	output logic                  log_hit,
	output logic                  trig_hit
);

	logic [CMP_WIDTH-1:0] w_ext;

	assign w_ext    = CMP_WIDTH'(wait_ms);
	assign is_high  = w_ext >= CMP_WIDTH'(cfg.high_thr);
	assign is_low   = !is_high && (w_ext >= CMP_WIDTH'(cfg.low_thr));
	assign log_hit  = is_high && cfg.log_en && (w_ext >= CMP_WIDTH'(cfg.log_thr));
	assign trig_hit = is_high && cfg.trigger_en && (w_ext >= CMP_WIDTH'(cfg.trigger_thr));

endmodule

>>> hw/rtl/alloc_latency_monitor.sv
// Top level of the allocation latency monitor.
//
//   channel   dir  data                                  user
//   s_*       in   wait_time_ms, page_order, zero pad    urgent_task, foreground_task
//   m_*       out  statistics after the request          log_event, trigger_event
//   cfg_*     in   register index, write data            -
//
// One request a cycle while the output is not stalled by m_tready; a request waits
// in the input register, then updates statistics and flag registers in the same edge.
// Statistics registers double as the result register: they change only when a
// new result is loaded, so they hold while the result waits for m_tready.
// Reset clears statistics, valid bits and enables and loads the default thresholds.
module alloc_latency_monitor
	import alm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// [31:0] wait_time_ms, [35:32] page_order, [39:36] zero
	input  logic [39:0]           s_tdata,
	// [0] urgent_task, [1] foreground_task
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [31:0] all_max_ms, [35:32] all_max_order, [67:36] all_high_count,
	// [99:68] all_low_count, [131:100] urgent_max_ms, [163:132] urgent_high_count,
	// [195:164] urgent_low_count, [227:196] fore_max_ms, [259:228] fore_high_count,
	// [291:260] fore_low_count, [295:292] zero
	output logic [295:0]          m_tdata,
	// [0] log_event, [1] trigger_event
	output logic [1:0]            m_tuser,
	input  logic                  cfg_we,
	input  logic [ADDR_WIDTH-1:0] cfg_addr,
	input  logic [THR_WIDTH-1:0]  cfg_wdata
);

	cfg_t                   cfg;
	logic                   v_s1;
	logic [WAIT_WIDTH-1:0]  wait_s1;
	logic [ORDER_WIDTH-1:0] order_s1;
	logic                   urg_s1;
	logic                   fore_s1;
	logic                   adv;
	logic                   out_valid_q;
	logic                   log_q;
	logic                   trig_q;
	logic [ORDER_WIDTH-1:0] order_q;
	logic                   is_high;
	logic                   is_low;
	logic                   log_hit;
	logic                   trig_hit;
	logic                   upd;
	class_ev_t              ev_all;
	class_ev_t              ev_urg;
	class_ev_t              ev_fore;
	logic                   all_new_peak;
	logic [WAIT_WIDTH-1:0]  all_peak;
	logic [WAIT_WIDTH-1:0]  urg_peak;
	logic [WAIT_WIDTH-1:0]  fore_peak;
	logic [COUNT_WIDTH-1:0] all_hi;
	logic [COUNT_WIDTH-1:0] all_lo;
	logic [COUNT_WIDTH-1:0] urg_hi;
	logic [COUNT_WIDTH-1:0] urg_lo;
	logic [COUNT_WIDTH-1:0] fore_hi;
	logic [COUNT_WIDTH-1:0] fore_lo;

	alm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv      = v_s1 && (!out_valid_q || m_tready);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			wait_s1  <= WAIT_WIDTH'(s_tdata[31:0]);
			order_s1 <= s_tdata[35:32];
			urg_s1   <= s_tuser[0];
			fore_s1  <= s_tuser[1];
		end
	end

	alm_event_class u_class (
		.cfg      (cfg),
		.wait_ms  (wait_s1),
		.is_high  (is_high),
		.is_low   (is_low),
		.log_hit  (log_hit),
		.trig_hit (trig_hit)
	);

	assign upd     = adv && cfg.monitor_en;
	assign ev_all  = '{update: upd, is_high: is_high, is_low: is_low};
	assign ev_urg  = '{update: upd && urg_s1, is_high: is_high, is_low: is_low};
	assign ev_fore = '{update: upd && fore_s1, is_high: is_high, is_low: is_low};

	assign all_new_peak = upd && (wait_s1 > all_peak);

	alm_class_stats u_all (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev         (ev_all),
		.wait_ms    (wait_s1),
		.peak       (all_peak),
		.high_total (all_hi),
		.low_cnt    (all_lo)
	);

	alm_class_stats u_urg (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev         (ev_urg),
		.wait_ms    (wait_s1),
		.peak       (urg_peak),
		.high_total (urg_hi),
		.low_cnt    (urg_lo)
	);

	alm_class_stats u_fore (
		.clk        (clk),
		.arst_n     (arst_n),
		.ev         (ev_fore),
		.wait_ms    (wait_s1),
		.peak       (fore_peak),
		.high_total (fore_hi),
		.low_cnt    (fore_lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			log_q       <= 1'b0;
			trig_q      <= 1'b0;
			order_q     <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				log_q       <= upd && log_hit;
				trig_q      <= upd && trig_hit;
			end else if (m_tready)
				out_valid_q <= 1'b0;
			if (all_new_peak)
				order_q <= order_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = {trig_q, log_q};
	assign m_tdata  = {
		4'd0,
		FIELD_WIDTH'(fore_lo),
		FIELD_WIDTH'(fore_hi),
		FIELD_WIDTH'(fore_peak),
		FIELD_WIDTH'(urg_lo),
		FIELD_WIDTH'(urg_hi),
		FIELD_WIDTH'(urg_peak),
		FIELD_WIDTH'(all_lo),
		FIELD_WIDTH'(all_hi),
		order_q,
		FIELD_WIDTH'(all_peak)
	};

endmodule
